[hdl/rpd_pkg.sv]
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared constants and types for the remote packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

  localparam int NUM_AXES_DEF = 4;   // axis bytes per frame
  localparam int HDR_BYTES    = 2;   // header bytes per frame
  localparam int OUT_AXES     = 4;   // axis fields on the result port
  localparam int BYTE_W       = 8;

  localparam logic [BYTE_W-1:0] HDR_MARK = 8'hFF;

  typedef enum logic [1:0] {
    ST_FRAME_OK   = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BAD_SUM    = 2'd2
  } frame_status_t;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    frame_status_t           status;
    byte_t [OUT_AXES-1:0]    axes;
  } rpd_result_t;

endpackage

[hdl/remote_packet_deframer.sv]
// ----------------------------------------------------------------------------
// remote_packet_deframer
// Groups received bytes into fixed frames and reports status and axis values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) takes one received byte
//   per word. Frames are counted from reset: two 0xFF header bytes,
//   NUM_AXES axis bytes, one checksum byte (inverted low byte of the axis sum).
//   There is no resynchronization.
//   Result channel (out_valid / out_stall / out_*) gives one word per frame,
//   on the checksum byte: status (0 ok, 1 bad header, 2 bad checksum) and
//   the held axis values, which change only on a good frame.
//   Path: an accepted checksum byte passes the input register, then the
//   result register, before out_valid rises.
//   Throughput: one byte per cycle while no stall holds the input; the frame
//   logic between the two registers sets this.
//   Reset: frame position, sum and held values clear; both registers empty.
//   Stall: a stalled result holds; header and axis bytes keep flowing, and a
//   checksum byte waits in the input register until the result register
//   frees, and stalls the input side while it waits.
// ----------------------------------------------------------------------------
module remote_packet_deframer #(
  parameter int NUM_AXES = rpd_pkg::NUM_AXES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_frame_status,
  output logic [7:0]             out_axis_zero,
  output logic [7:0]             out_axis_one,
  output logic [7:0]             out_axis_two,
  output logic [7:0]             out_axis_three
);
  import rpd_pkg::*;

  logic        s1_valid;
  byte_t       s1_byte;
  logic        take;
  logic        last;
  logic        out_ready;
  rpd_result_t res;
  rpd_result_t out_res;

  // a closing byte needs room in the result register
  assign take = s1_valid && (!last || out_ready);

  rpd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_rx_byte),
    .in_stall (in_stall),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  rpd_frame #(
    .NUM_AXES (NUM_AXES)
  ) u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (take),
    .rx_byte (s1_byte),
    .last    (last),
    .res     (res)
  );

  rpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && last),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_frame_status = out_res.status;
  assign out_axis_zero    = out_res.axes[0];
  assign out_axis_one     = out_res.axes[1];
  assign out_axis_two     = out_res.axes[2];
  assign out_axis_three   = out_res.axes[3];

endmodule

[hdl/rpd_in_stage.sv]
// ----------------------------------------------------------------------------
// rpd_in_stage
// Input register: captures one received byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module rpd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  rpd_pkg::byte_t    in_byte,
  output logic              in_stall,
  input  logic              take,      // stage word consumed this cycle
  output logic              s1_valid,
  output rpd_pkg::byte_t    s1_byte
);
  import rpd_pkg::*;

  logic   s1_valid_r;
  logic   s1_valid_nxt;
  byte_t  s1_byte_r;
  logic   load;

  assign load         = !s1_valid_r || take;
  assign in_stall     = !load;
  assign s1_valid_nxt = load ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      s1_byte_r <= in_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

[hdl/rpd_frame.sv]
// ----------------------------------------------------------------------------
// rpd_frame
// Frame tracker: byte position, running sum, header flag, pending and held
// axis values, and the end-of-frame status.
// ----------------------------------------------------------------------------
module rpd_frame #(
  parameter int NUM_AXES = rpd_pkg::NUM_AXES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,        // stage word processed this cycle
  input  rpd_pkg::byte_t       rx_byte,
  output logic                 last,      // stage word closes a frame
  output rpd_pkg::rpd_result_t res
);
  import rpd_pkg::*;

  localparam int FRAME_LEN = HDR_BYTES + NUM_AXES + 1;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int AIDX_W    = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  byte_t             sum_r, sum_nxt;
  logic              hdr_good_r, hdr_good_nxt;
  byte_t             pend_r [NUM_AXES];
  byte_t             held_r [NUM_AXES];
  byte_t             held_nxt [NUM_AXES];

  logic              in_hdr;
  logic              in_axis;
  logic              frame_ok;
  logic [POS_W-1:0]  axis_off;
  logic [AIDX_W-1:0] aidx;
  frame_status_t     status;

  always_comb begin
    in_hdr   = pos_r < POS_W'(HDR_BYTES);
    in_axis  = !in_hdr && (pos_r < POS_W'(HDR_BYTES + NUM_AXES));
    last     = pos_r == POS_W'(FRAME_LEN - 1);
    axis_off = pos_r - POS_W'(HDR_BYTES);
    aidx     = axis_off[AIDX_W-1:0];

    // bad header wins over a bad checksum
    if (!hdr_good_r) begin
      status = ST_BAD_HEADER;
    end else if (~sum_r != rx_byte) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_FRAME_OK;
    end
    frame_ok = go && last && (status == ST_FRAME_OK);

    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    hdr_good_nxt = hdr_good_r;
    if (go) begin
      if (last) begin
        pos_nxt      = '0;
        sum_nxt      = '0;
        hdr_good_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (in_hdr) begin
          if (rx_byte != HDR_MARK) begin
            hdr_good_nxt = 1'b0;
          end
        end else begin
          sum_nxt = sum_r + rx_byte;
        end
      end
    end

    for (int k = 0; k < NUM_AXES; k++) begin
      held_nxt[k] = frame_ok ? pend_r[k] : held_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      sum_r      <= '0;
      hdr_good_r <= 1'b1;
      for (int k = 0; k < NUM_AXES; k++) begin
        held_r[k] <= '0;
      end
    end else begin
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      hdr_good_r <= hdr_good_nxt;
      for (int k = 0; k < NUM_AXES; k++) begin
        held_r[k] <= held_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_axis) begin
      pend_r[aidx] <= rx_byte;
    end
  end

  assign res.status = status;

  // result fields without an axis behind them read as zero
  for (genvar g = 0; g < OUT_AXES; g++) begin : g_out_axis
    if (g < NUM_AXES) begin : g_live
      assign res.axes[g] = held_nxt[g];
    end else begin : g_zero
      assign res.axes[g] = '0;
    end
  end

endmodule

[hdl/rpd_out_stage.sv]
// ----------------------------------------------------------------------------
// rpd_out_stage
// Result register: holds one frame result until the receiver takes it.
// ----------------------------------------------------------------------------
module rpd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  rpd_pkg::rpd_result_t res,
  output logic                 ready,     // register free or emptying now
  output logic                 out_valid,
  input  logic                 out_stall,
  output rpd_pkg::rpd_result_t out_res
);
  import rpd_pkg::*;

  logic        valid_r, valid_nxt;
  rpd_result_t res_r;

  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ready) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
